/* src/pkd_pkg.sv */
// Shared types and constants for the per-pixel Kalman denoiser.
// Holds the pipeline item layout, stage numbering and register index codes.
// No dependencies.
package pkd_pkg;

   // configuration register indexes
   localparam logic [3:0] CSR_Q_GAIN    = 4'd0;
   localparam logic [3:0] CSR_R_INITIAL = 4'd1;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic [23:0] Q_GAIN_RESET    = 24'd3277;
   localparam logic [31:0] R_INITIAL_RESET = 32'd65536;
   localparam logic [31:0] VAR_ONE         = 32'd65536;
   localparam logic [15:0] GAIN_HALF       = 16'd32768;

   // stage numbering (stage s holds the item after s steps)
   localparam int ST_SETUP   = 1;
   localparam int ST_PROD    = 2;
   localparam int ST_PP      = 3;
   localparam int DIV1_FIRST = 2;
   localparam int DIV1_LAST  = 33;
   localparam int ST_RN      = 34;
   localparam int ST_D2      = 35;
   localparam int DIV2_FIRST = 36;
   localparam int DIV2_LAST  = 51;
   localparam int ST_OMK     = 52;
   localparam int ST_MUL     = 53;
   localparam int ST_INNER   = 54;
   localparam int ST_V1      = 55;
   localparam int ST_OUT     = 56;
   localparam int NSTAGE     = 57;

   // stored state: estimate, variance, gain, noise, prior blur
   localparam int ENTRY_W = 112;

   typedef struct packed {
      logic        op;
      logic [18:0] addr;
      logic [7:0]  f;
      logic [15:0] b;
      logic [15:0] bf;
      logic [15:0] x;
      logic [31:0] p;
      logic [15:0] k;
      logic [31:0] r;
      logic [15:0] pb;
      logic [31:0] sq;
      logic [55:0] prod;
      logic [16:0] d1;
      logic [16:0] rem1;
      logic [31:0] nb1;
      logic [31:0] q1;
      logic [31:0] rn;
      logic [32:0] d2;
      logic [32:0] rem2;
      logic [15:0] kn;
      logic [16:0] omk;
      logic [32:0] ma;
      logic [31:0] mb;
      logic [31:0] mc;
      logic [48:0] md;
      logic [33:0] inner;
      logic [31:0] pn;
      logic [50:0] v1;
      logic [7:0]  pix;
   } item_type;

endpackage

/* src/per_pixel_kalman_denoise.sv */
// Per-pixel adaptive Kalman denoiser, top level.
// Throughput: one transaction per cycle while the result output is not stalled;
// an item whose pixel entry is still in flight in the 57-stage read-modify-write
// pipeline is held off until its write.
// Two pipelined restoring dividers (32 and 16 steps) set the depth.
// Reset (synchronous) clears pipeline valids, the result valid and config
// registers; the state memory is not cleared (a load must precede a filter).
module per_pixel_kalman_denoise #(
   parameter int MAX_PIXELS = 524288
) (
   input  logic        clock,
   input  logic        reset,
   // input transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [18:0] req_pixel_addr,
   input  logic [7:0]  req_pixel_value,
   input  logic [15:0] req_box_mean,
   input  logic [15:0] req_bilateral_value,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [18:0] rsp_out_addr,
   output logic [7:0]  rsp_filtered_pixel,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pkd_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam bit POW2 = ((MAX_PIXELS & (MAX_PIXELS - 1)) == 0);
   localparam int LAST = NSTAGE - 1;

   // ---------------------------------------------------------------------
   // Address reduction modulo the store depth
   // ---------------------------------------------------------------------
   function automatic logic [AW-1:0] reduce_fn(input logic [18:0] a);
      logic [43:0] w;
      logic [43:0] m;
      w = {25'd0, a};
      if (MAX_PIXELS == 1) begin
         // single-entry store: every address maps to entry zero
         w = '0;
      end else if (!POW2) begin
         for (int j = 19; j >= 0; j--) begin
            m = 44'(MAX_PIXELS) << j;
            if (w >= m) begin
               w = w - m;
            end
         end
      end
      return w[AW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // One pipeline step: stage s applied to the item leaving stage s-1
   // ---------------------------------------------------------------------
   function automatic item_type step_fn(input int s, input item_type it,
                                        input logic [23:0] qg);
      item_type    o;
      logic [15:0] dmag;
      logic [17:0] t1;
      logic [33:0] t2;
      logic [40:0] psum;
      logic [32:0] rsum;
      logic [51:0] v;
      logic [19:0] xr;
      logic [16:0] pr;
      o = it;
      if (s == ST_SETUP) begin
         dmag   = (it.pb >= it.b) ? (it.pb - it.b) : (it.b - it.pb);
         o.sq   = dmag * dmag;
         o.d1   = 17'h10000 + {1'b0, it.k};
         o.rem1 = {1'b0, it.r[31:16]};
         o.nb1  = {it.r[15:0], 16'h0000};
         o.q1   = '0;
      end
      if (s == ST_PROD) begin
         o.prod = 56'(qg) * 56'(it.sq);
      end
      if (s == ST_PP) begin
         psum = 41'(it.p) + 41'(it.prod[55:16]);
         o.p  = (psum > 41'hFFFF_FFFF) ? 32'hFFFF_FFFF : psum[31:0];
      end
      if (s >= DIV1_FIRST && s <= DIV1_LAST) begin
         t1 = {it.rem1, it.nb1[31]};
         o.nb1 = {it.nb1[30:0], 1'b0};
         if (t1 >= {1'b0, it.d1}) begin
            o.rem1 = 17'(t1 - {1'b0, it.d1});
            o.q1   = {it.q1[30:0], 1'b1};
         end else begin
            o.rem1 = t1[16:0];
            o.q1   = {it.q1[30:0], 1'b0};
         end
      end
      if (s == ST_RN) begin
         rsum = 33'(it.q1) + 33'h10000;
         o.rn = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
      end
      if (s == ST_D2) begin
         o.d2   = 33'(it.p) + 33'(it.rn);
         o.rem2 = {1'b0, it.p};
         o.kn   = '0;
      end
      if (s >= DIV2_FIRST && s <= DIV2_LAST) begin
         t2 = {it.rem2, 1'b0};
         if (t2 >= {1'b0, it.d2}) begin
            o.rem2 = 33'(t2 - {1'b0, it.d2});
            o.kn   = {it.kn[14:0], 1'b1};
         end else begin
            o.rem2 = t2[32:0];
            o.kn   = {it.kn[14:0], 1'b0};
         end
      end
      if (s == ST_OMK) begin
         o.omk = 17'h10000 - {1'b0, it.kn};
      end
      if (s == ST_MUL) begin
         o.ma = it.omk * it.x;
         o.mb = it.kn * {it.f, 8'h00};
         o.mc = it.kn * it.bf;
         o.md = 49'(it.p) * 49'(it.omk);
      end
      if (s == ST_INNER) begin
         o.inner = 34'(it.ma) + 34'(it.mb);
         o.pn    = it.md[47:16];
      end
      if (s == ST_V1) begin
         o.v1 = 51'(it.omk) * 51'(it.inner);
      end
      if (s == ST_OUT) begin
         v   = 52'(it.v1) + 52'({it.mc, 16'h0000}) + 52'h8000_0000;
         xr  = v[51:32];
         o.x = (xr > 20'hFFFF) ? 16'hFFFF : xr[15:0];
         pr  = 17'(o.x) + 17'd128;
         o.pix = (pr[16:8] > 9'd255) ? 8'hFF : pr[15:8];
      end
      return o;
   endfunction

   // configuration
   logic [23:0] q_gain_ff;
   logic [31:0] r_initial_ff;

   // pipeline
   logic              valid_ff [NSTAGE];
   item_type          st_ff    [NSTAGE];
   logic [AW-1:0]     idx_ff   [NSTAGE];
   logic [ENTRY_W-1:0] rd_ff;
   item_type          st0_full;
   item_type          in_item;

   // state memory
   logic [ENTRY_W-1:0] mem [MAX_PIXELS];
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   logic          advance;
   logic          hazard;
   logic          accept;
   logic [AW-1:0] acc_idx;
   logic          last_out;

   logic        rsp_valid_ff;
   logic [18:0] rsp_addr_ff;
   logic [7:0]  rsp_pix_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_gain_ff    <= Q_GAIN_RESET;
         r_initial_ff <= R_INITIAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_Q_GAIN:    q_gain_ff    <= csr_data[23:0];
            CSR_R_INITIAL: r_initial_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // last stage holds a result that needs the output register
   assign last_out = valid_ff[LAST] && (st_ff[LAST].op == OP_FILTER);
   // freeze only when a result cannot leave
   assign advance  = !(rsp_valid_ff && rsp_stall && last_out);

   assign acc_idx = reduce_fn(req_pixel_addr);

   // interlock: no two transactions on one entry in flight at once
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < NSTAGE; i++) begin
         if (valid_ff[i] && idx_ff[i] == acc_idx) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_stall = !advance || hazard;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_item      = '0;
      in_item.op   = req_opcode;
      in_item.addr = req_pixel_addr;
      in_item.f    = req_pixel_value;
      in_item.b    = req_box_mean;
      in_item.bf   = req_bilateral_value;
   end

   // merge memory read data into the item entering the datapath
   always_comb begin
      st0_full    = st_ff[0];
      st0_full.x  = rd_ff[111:96];
      st0_full.p  = rd_ff[95:64];
      st0_full.k  = rd_ff[63:48];
      st0_full.r  = rd_ff[47:16];
      st0_full.pb = rd_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= accept;
         for (int i = 1; i < NSTAGE; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (accept) begin
            st_ff[0]  <= in_item;
            idx_ff[0] <= acc_idx;
         end
         st_ff[1]  <= step_fn(1, st0_full, q_gain_ff);
         idx_ff[1] <= idx_ff[0];
         for (int i = 2; i < NSTAGE; i++) begin
            st_ff[i]  <= step_fn(i, st_ff[i-1], q_gain_ff);
            idx_ff[i] <= idx_ff[i-1];
         end
      end
   end

   // read at acceptance, write back from the last stage
   assign wr_en = advance && valid_ff[LAST];

   always_comb begin
      if (st_ff[LAST].op == OP_LOAD) begin
         wr_data = {st_ff[LAST].f, 8'h00, VAR_ONE, GAIN_HALF, r_initial_ff, 16'h0000};
      end else begin
         wr_data = {st_ff[LAST].x, st_ff[LAST].pn, st_ff[LAST].kn, st_ff[LAST].rn,
                    st_ff[LAST].b};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[acc_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff[LAST]] <= wr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && last_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_out) begin
         rsp_addr_ff <= st_ff[LAST].addr;
         rsp_pix_ff  <= st_ff[LAST].pix;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_addr       = rsp_addr_ff;
   assign rsp_filtered_pixel = rsp_pix_ff;

   // a write-back never lands on the entry read in the same cycle
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (accept && wr_en) |-> (acc_idx != idx_ff[LAST]))
      else $error("read and write-back hit the same entry");

   // a new result comes only from a filter transaction leaving the pipeline
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_out && advance))
      else $error("result without a filter transaction");

   // updated gain never reaches one, so one minus gain is nonzero
   a_omk_nonzero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_OMK] && st_ff[ST_OMK].op == OP_FILTER) |-> (st_ff[ST_OMK].omk != 17'd0))
      else $error("gain complement is zero");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for per_pixel_kalman_denoise.
// Depends on pkd_pkg and the block itself. It predicts every filtered pixel
// from its own copy of the per-pixel Kalman state and checks the result stream.
module tb_top;
   import pkd_pkg::*;

   typedef struct {
      logic        op;
      logic [18:0] addr;
      logic [7:0]  f;
      logic [15:0] b;
      logic [15:0] bf;
   } pixel_req_type;

   typedef struct {
      logic [18:0] addr;
      logic [7:0]  pix;
   } pixel_rsp_type;

   typedef struct {
      logic [3:0]  index;
      logic [31:0] data;
   } reg_write_type;

   localparam int DRAIN_CYCLES = 80;    // pipeline is 57 deep
   localparam int STUCK_LIMIT  = 20000;
   localparam int PHASE_ITEMS  = 470;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_LOAD;
   logic [18:0] req_pixel_addr = '0;
   logic [7:0]  req_pixel_value = '0;
   logic [15:0] req_box_mean = '0;
   logic [15:0] req_bilateral_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [18:0] rsp_out_addr;
   logic [7:0]  rsp_filtered_pixel;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   per_pixel_kalman_denoise DUT (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: per-pixel Kalman entries plus register copies.
   // Only loaded entries are ever filtered, so sparse arrays suffice.
   // ---------------------------------------------------------------
   logic [15:0] est_mem   [int];
   logic [31:0] var_mem   [int];
   logic [15:0] gain_mem  [int];
   logic [31:0] noise_mem [int];
   logic [15:0] blur_mem  [int];
   logic [23:0] q_gain_reg    = Q_GAIN_RESET;
   logic [31:0] r_initial_reg = R_INITIAL_RESET;

   pixel_req_type pending_pixels[$];
   reg_write_type pending_writes[$];
   pixel_rsp_type expected_pixels[$];
   int            error_count = 0;

   function automatic logic [63:0] sat32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   // One Kalman update (or load) on the predictor state; pushes a result
   // expectation for filter transactions.
   task automatic kalman_update(pixel_req_type t);
      int          a;
      logic [63:0] x, p, k, r, pb, fx, dmag, rn, pp, kn, omk, inner, v, xn, pn, pix;
      a = int'(t.addr);
      if (t.op == OP_LOAD) begin
         est_mem[a]   = {t.f, 8'd0};
         var_mem[a]   = VAR_ONE;
         gain_mem[a]  = GAIN_HALF;
         noise_mem[a] = r_initial_reg;
         blur_mem[a]  = 16'd0;
      end else begin
         x  = est_mem[a];
         p  = var_mem[a];
         k  = gain_mem[a];
         r  = noise_mem[a];
         pb = blur_mem[a];
         fx = {t.f, 8'd0};
         dmag = (pb >= t.b) ? pb - t.b : t.b - pb;
         // noise adapts from the previous gain, variance grows with blur change
         rn = sat32(64'd65536 + ((r << 16) / (64'd65536 + k)));
         pp = sat32(p + ((64'(q_gain_reg) * (dmag * dmag)) >> 16));
         kn = (pp << 16) / (pp + rn);
         omk = 64'd65536 - kn;
         inner = omk * x + kn * fx;
         v  = omk * inner + ((kn * t.bf) << 16);
         xn = (v + 64'h8000_0000) >> 32;
         if (xn > 64'd65535) xn = 64'd65535;
         pn = (pp * omk) >> 16;
         est_mem[a]   = xn[15:0];
         var_mem[a]   = pn[31:0];
         gain_mem[a]  = kn[15:0];
         noise_mem[a] = rn[31:0];
         blur_mem[a]  = t.b;
         pix = (xn + 64'd128) >> 8;
         if (pix > 64'd255) pix = 64'd255;
         expected_pixels.push_back('{t.addr, pix[7:0]});
      end
   endtask

   // idle gaps: mostly none or short, a few long; bursts without any idling
   bit burst_mode = 1'b0;
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (burst_mode) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // ---------------------------------------------------------------
   // Driver: pixel transactions and register writes, all at the clock edge
   // ---------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      pixel_req_type cur;
      reg_write_type w;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if ($urandom_range(199) == 0) burst_mode = ~burst_mode;
         // pixel channel
         if (req_valid && !req_stall) begin
            cur = pending_pixels.pop_front();
            kalman_update(cur);
            send_gap = pick_gap();
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               cur = pending_pixels[0];
               req_valid           <= 1'b1;
               req_opcode          <= cur.op;
               req_pixel_addr      <= cur.addr;
               req_pixel_value     <= cur.f;
               req_box_mean        <= cur.b;
               req_bilateral_value <= cur.bf;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // register channel
         if (csr_valid && csr_ready) begin
            w = pending_writes.pop_front();
            if (w.index == CSR_Q_GAIN) q_gain_reg = w.data[23:0];
            else if (w.index == CSR_R_INITIAL) r_initial_reg = w.data;
         end
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() > 0) begin
               csr_valid <= 1'b1;
               csr_index <= pending_writes[0].index;
               csr_data  <= pending_writes[0].data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: result transactions against the oldest expectation
   // ---------------------------------------------------------------
   int stall_gap = 0;
   always @(posedge clock) begin
      pixel_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: out_addr %0d filtered_pixel %0d",
                   rsp_out_addr, rsp_filtered_pixel);
            error_count++;
         end else begin
            exp_rsp = expected_pixels.pop_front();
            if (rsp_out_addr !== exp_rsp.addr) begin
               $error("out_addr: expected %0d, got %0d", exp_rsp.addr, rsp_out_addr);
               error_count++;
            end
            if (rsp_filtered_pixel !== exp_rsp.pix) begin
               $error("filtered_pixel: expected %0d, got %0d",
                      exp_rsp.pix, rsp_filtered_pixel);
               error_count++;
            end
         end
      end
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else begin
         stall_gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
         rsp_stall <= (stall_gap > 0);
      end
   end

   // Watchdog: cycles with no transaction on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [18:0] loaded_addrs[$];   // entries a load has written
   bit          is_loaded[int];

   task automatic add_pixel(logic op, logic [18:0] addr, logic [7:0] f,
                            logic [15:0] b, logic [15:0] bf);
      pending_pixels.push_back('{op, addr, f, b, bf});
      if (op == OP_LOAD && !is_loaded.exists(int'(addr))) begin
         is_loaded[int'(addr)] = 1'b1;
         loaded_addrs.push_back(addr);
      end
   endtask

   task automatic add_write(logic [3:0] index, logic [31:0] data);
      pending_writes.push_back('{index, data});
   endtask

   // let everything in flight finish, so registers change only when idle
   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_valid || pending_writes.size() > 0 ||
             csr_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_blur();
      // small values keep variance unsaturated; full range hits saturation
      return ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
   endfunction

   task automatic random_phase(int count);
      logic [18:0] addr;
      for (int i = 0; i < count; i++) begin
         if (loaded_addrs.size() == 0 || $urandom_range(99) < 12) begin
            // reseed a known entry or open a new one (pool kept small for hazards)
            if (loaded_addrs.size() > 0 && (loaded_addrs.size() >= 24 ||
                $urandom_range(1) == 0))
               addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
            else
               addr = 19'($urandom);
            add_pixel(OP_LOAD, addr, 8'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
            add_pixel(OP_FILTER, addr, 8'($urandom), rand_blur(), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: address and field extremes at reset register values
      add_pixel(OP_LOAD,   19'd0,      8'd0,   16'd0,     16'd0);
      add_pixel(OP_LOAD,   19'h7FFFF,  8'd255, 16'hFFFF,  16'hFFFF);
      add_pixel(OP_FILTER, 19'd0,      8'd0,   16'd0,     16'd0);
      add_pixel(OP_FILTER, 19'h7FFFF,  8'd255, 16'hFFFF,  16'hFFFF);
      add_pixel(OP_FILTER, 19'h7FFFF,  8'd255, 16'd0,     16'hFFFF);
      add_pixel(OP_FILTER, 19'd0,      8'd255, 16'hFFFF,  16'hFFFF);
      add_pixel(OP_FILTER, 19'd0,      8'd0,   16'd0,     16'd0);
      add_pixel(OP_LOAD,   19'h2AAAA,  8'h80,  16'h1234,  16'h8000);
      add_pixel(OP_FILTER, 19'h2AAAA,  8'h7F,  16'h8080,  16'h7FFF);
      add_pixel(OP_FILTER, 19'h2AAAA,  8'h80,  16'h8080,  16'h8000);
      random_phase(PHASE_ITEMS);
      wait_idle();

      // zero process noise gain, zero initial noise
      add_write(CSR_Q_GAIN, 32'd0);
      add_write(CSR_R_INITIAL, 32'd0);
      wait_idle();
      add_pixel(OP_LOAD,   19'h55555, 8'd255, 16'd0,    16'd0);
      add_pixel(OP_FILTER, 19'h55555, 8'd0,   16'hFFFF, 16'd0);
      random_phase(PHASE_ITEMS);
      wait_idle();

      // largest gain and noise: saturation of noise, variance and output
      add_write(CSR_Q_GAIN, 32'h00FF_FFFF);
      add_write(CSR_R_INITIAL, 32'hFFFF_FFFF);
      wait_idle();
      add_pixel(OP_LOAD,   19'h12345, 8'd255, 16'd0,    16'hFFFF);
      add_pixel(OP_FILTER, 19'h12345, 8'd255, 16'hFFFF, 16'hFFFF);
      add_pixel(OP_FILTER, 19'h12345, 8'd255, 16'd0,    16'hFFFF);
      random_phase(PHASE_ITEMS);
      wait_idle();

      // random settings
      add_write(CSR_Q_GAIN, 32'($urandom_range(24'hFFFFFF)));
      add_write(CSR_R_INITIAL, $urandom);
      wait_idle();
      random_phase(PHASE_ITEMS);
      wait_idle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
